FILE: hw/rtl/spq_pkg.sv
// Shared types, opcodes and defaults for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int HANDLE_BITS_DEFAULT = 16;

    localparam int OPCODE_W   = 2;
    localparam int PRIORITY_W = 32;
    localparam int TASK_W     = 16;
    localparam int CAP_W      = 5;
    localparam int COUNT_W    = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]          opcode;
        logic signed [PRIORITY_W-1:0] priority_req;
        logic [TASK_W-1:0]            task_handle;
    } req_t;

    typedef struct packed {
        logic                         accepted;
        logic                         head_valid;
        logic signed [PRIORITY_W-1:0] head_priority;
        logic [TASK_W-1:0]            head_task;
        logic [COUNT_W-1:0]           entry_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

FILE: hw/rtl/spq_ctrl.sv
// Controller that sequences each request through load and execute.
module spq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output spq_pkg::cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: hw/rtl/spq_datapath.sv
// Sorted entry array with parallel compare, insert and shift, plus the result register.
module spq_datapath
#(
    parameter int DEPTH       = spq_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  spq_pkg::cmd_t               cmd,
    input  spq_pkg::req_t               req,
    input  logic                        cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]   cfg_wdata,
    output spq_pkg::rsp_t               rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

    spq_pkg::req_t                        req_reg;
    spq_pkg::rsp_t                        rsp_reg;
    spq_pkg::rsp_t                        rsp_next;
    logic [spq_pkg::CAP_W-1:0]            capacity_reg;
    logic [CW-1:0]                        count_reg;
    logic [CW-1:0]                        count_next;
    logic signed [spq_pkg::PRIORITY_W-1:0] prio_reg  [DEPTH];
    logic signed [spq_pkg::PRIORITY_W-1:0] prio_next [DEPTH];
    logic [HANDLE_BITS-1:0]               task_reg  [DEPTH];
    logic [HANDLE_BITS-1:0]               task_next [DEPTH];
    logic [DEPTH-1:0]                     ins;
    logic                                 is_add;
    logic                                 is_complete;
    logic                                 can_add;
    logic                                 can_complete;
    logic                                 do_add;
    logic                                 do_complete;
    logic [HANDLE_BITS-1:0]               new_task;

    assign is_add       = (req_reg.opcode == spq_pkg::OP_ADD);
    assign is_complete  = (req_reg.opcode == spq_pkg::OP_COMPLETE);
    assign can_add      = (LW'(count_reg) < LW'(capacity_reg))
                          && (LW'(count_reg) < LW'(DEPTH));
    assign can_complete = (count_reg != '0);
    assign do_add       = is_add && can_add;
    assign do_complete  = is_complete && can_complete;
    assign new_task     = HANDLE_BITS'(req_reg.task_handle);

    // The new entry goes at the first place whose priority is strictly lower, or at the tail.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic gt;
            assign gt     = (CW'(g) < count_reg) && (req_reg.priority_req > prio_reg[g]);
            assign ins[g] = gt || (CW'(g) == count_reg);

            if (g == 0)
            begin : g_head
                always_comb
                begin
                    prio_next[g] = prio_reg[g];
                    task_next[g] = task_reg[g];
                    if (do_add && ins[g])
                    begin
                        prio_next[g] = req_reg.priority_req;
                        task_next[g] = new_task;
                    end
                    else if (do_complete && (DEPTH > 1))
                    begin
                        prio_next[g] = prio_reg[(DEPTH > 1) ? 1 : 0];
                        task_next[g] = task_reg[(DEPTH > 1) ? 1 : 0];
                    end
                end
            end
            else
            begin : g_body
                always_comb
                begin
                    prio_next[g] = prio_reg[g];
                    task_next[g] = task_reg[g];
                    if (do_add && ins[g] && !ins[g-1])
                    begin
                        prio_next[g] = req_reg.priority_req;
                        task_next[g] = new_task;
                    end
                    else if (do_add && ins[g] && ins[g-1])
                    begin
                        prio_next[g] = prio_reg[g-1];
                        task_next[g] = task_reg[g-1];
                    end
                    else if (do_complete && (g < DEPTH - 1))
                    begin
                        prio_next[g] = prio_reg[(g < DEPTH - 1) ? g + 1 : g];
                        task_next[g] = task_reg[(g < DEPTH - 1) ? g + 1 : g];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_add)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_complete)
        begin
            count_next = count_reg - CW'(1);
        end

        rsp_next.accepted    = do_add || do_complete || (req_reg.opcode == spq_pkg::OP_QUERY);
        rsp_next.head_valid  = (count_next != '0);
        rsp_next.entry_count = spq_pkg::COUNT_W'(count_next);
        if (count_next != '0)
        begin
            rsp_next.head_priority = prio_next[0];
            rsp_next.head_task     = spq_pkg::TASK_W'(task_next[0]);
        end
        else
        begin
            rsp_next.head_priority = '0;
            rsp_next.head_task     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= spq_pkg::CAPACITY_RESET;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                prio_reg[i] <= prio_next[i];
                task_reg[i] <= task_next[i];
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller and entry datapath.
// A request accepted on start is captured in the request register, then executed; its response is registered with done.
// busy is high for the one execute cycle, so no new request is taken while the previous one executes.
// The execute cycle compares the new priority against every entry and shifts in parallel.
// The response stays on rsp until the next request executes; the receiver cannot stall it.
// Reset empties the queue and sets capacity to 16; stored entries are not cleared.
module sorted_priority_queue
#(
    parameter int DEPTH       = spq_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  spq_pkg::req_t             req,
    output logic                      done,
    output spq_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [spq_pkg::CAP_W-1:0] cfg_wdata
);

    spq_pkg::cmd_t cmd;

    spq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    spq_datapath
    #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule
